// ===== rtl/scld_pkg.sv =====
package scld_pkg;

    localparam int LINE_DEPTH = 20;
    localparam int KEY_MAX    = 6;
    localparam int NUM_KEYS   = 13;
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
    localparam int KIDX_W     = $clog2(KEY_MAX);
    localparam int CODE_W     = 4;

    localparam logic [7:0] BYTE_NUL = 8'd0;
    localparam logic [7:0] BYTE_BS  = 8'd8;
    localparam logic [7:0] BYTE_LF  = 8'd10;
    localparam logic [7:0] BYTE_CR  = 8'd13;
    localparam logic [7:0] BYTE_DEL = 8'd127;

    localparam logic KIND_ECHO     = 1'b0;
    localparam logic KIND_DECISION = 1'b1;

    localparam logic [CODE_W-1:0] CODE_INVALID = '0;

    typedef logic [7:0] t_line [KEY_MAX];

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LF,
        PH_DECIDE
    } t_phase;

    typedef struct packed {
        logic       append;
        logic       remove;
        logic       clear;
        logic [7:0] data;
    } t_line_cmd;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [CODE_W-1:0] code;
    } t_line_stat;

    localparam logic [LEN_W-1:0] KEY_LEN [NUM_KEYS] = '{
        LEN_W'(5), LEN_W'(6), LEN_W'(5), LEN_W'(5), LEN_W'(5), LEN_W'(5), LEN_W'(4),
        LEN_W'(5), LEN_W'(5), LEN_W'(5), LEN_W'(5), LEN_W'(5), LEN_W'(5)
    };

    localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_MAX] = '{
        '{"F", "A", "N", "O", "N", 8'h00},
        '{"F", "A", "N", "O", "F", "F"},
        '{"F", "A", "N", "2", "0", 8'h00},
        '{"F", "A", "N", "8", "0", 8'h00},
        '{"P", "I", "D", "3", "0", 8'h00},
        '{"P", "I", "D", "6", "0", 8'h00},
        '{"P", "I", "D", "5", 8'h00, 8'h00},
        '{"P", "I", "D", "5", "0", 8'h00},
        '{"P", "I", "D", "8", "0", 8'h00},
        '{"P", "I", "D", "7", "5", 8'h00},
        '{"P", "I", "D", "8", "4", 8'h00},
        '{"P", "I", "D", "9", "0", 8'h00},
        '{"P", "I", "D", "9", "4", 8'h00}
    };

    // exact whole-line match against the keyword table, first hit wins
    function automatic logic [CODE_W-1:0] match_line(input t_line line,
                                                     input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] code;
        logic              hit;
        code = CODE_INVALID;
        for (int k = 0; k < NUM_KEYS; k++) begin
            hit = (len == KEY_LEN[k]);
            for (int i = 0; i < KEY_MAX; i++) begin
                if ((LEN_W'(i) < KEY_LEN[k]) && (line[i] != KEY_TEXT[k][i])) begin
                    hit = 1'b0;
                end
            end
            if (hit && (code == CODE_INVALID)) begin
                code = CODE_W'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

// ===== rtl/scld_line.sv =====
module scld_line
    import scld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_line_cmd  i_cmd,
    output t_line_stat o_stat
);

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    // only the leading characters can take part in a match, so only they are kept
    t_line            r_store;

    always_comb begin
        n_len = r_len;
        if (i_cmd.clear) begin
            n_len = '0;
        end else if (i_cmd.remove && (r_len != '0)) begin
            n_len = r_len - LEN_W'(1);
        end else if (i_cmd.append && (r_len != LEN_W'(LINE_DEPTH))) begin
            n_len = r_len + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !i_cmd.clear && !i_cmd.remove
            && (r_len < LEN_W'(KEY_MAX))) begin
            r_store[r_len[KIDX_W-1:0]] <= i_cmd.data;
        end
    end

    assign o_stat.empty = (r_len == '0);
    assign o_stat.full  = (r_len == LEN_W'(LINE_DEPTH));
    assign o_stat.code  = match_line(r_store, r_len);

endmodule

// ===== rtl/serial_command_line_decoder.sv =====
// a byte is held in the input register, its result then in the result register
// throughput: one byte per cycle while results are taken; a carriage return holds
//   the result register (CR echo, LF echo, decision) before a new byte is taken
// the single result register sets the pace, one result per cycle unless stalled
// reset (synchronous, active low) empties the line and drops pending results
module serial_command_line_decoder
    import scld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic              o_kind,
    output logic [7:0]        o_echo_byte,
    output logic [CODE_W-1:0] o_command_code,
    output logic              o_last
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    t_phase            r_phase;
    t_phase            n_phase;
    logic [CODE_W-1:0] r_code;
    logic [CODE_W-1:0] n_code;
    logic              r_out_vld;
    logic              n_out_vld;
    logic              r_out_kind;
    logic              n_out_kind;
    logic [7:0]        r_out_echo;
    logic [7:0]        n_out_echo;
    logic [CODE_W-1:0] r_out_code;
    logic [CODE_W-1:0] n_out_code;
    logic              r_out_last;
    logic              n_out_last;

    logic              out_free;
    logic              consume;
    t_line_cmd         line_cmd;
    t_line_stat        line_stat;

    scld_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (line_cmd),
        .o_stat  (line_stat)
    );

    assign out_free   = !r_out_vld || i_res_ready;
    assign consume    = out_free && (r_phase == PH_IDLE) && r_in_vld;
    assign o_rx_ready = !r_in_vld || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_vld <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // next phase of the carriage return sequence
    always_comb begin
        n_phase = r_phase;
        n_code  = r_code;
        if (out_free) begin
            case (r_phase)
                PH_LF:     n_phase = PH_DECIDE;
                PH_DECIDE: n_phase = PH_IDLE;
                PH_IDLE: begin
                    if (consume && (r_in_byte == BYTE_CR)) begin
                        n_phase = PH_LF;
                        n_code  = line_stat.code;
                    end
                end
                default:   n_phase = PH_IDLE;
            endcase
        end
    end

    // result register and line edits
    always_comb begin
        n_out_vld  = r_out_vld;
        n_out_kind = r_out_kind;
        n_out_echo = r_out_echo;
        n_out_code = r_out_code;
        n_out_last = r_out_last;
        line_cmd   = '0;
        line_cmd.data = r_in_byte;
        if (out_free) begin
            n_out_vld = 1'b0;
            case (r_phase)
                PH_LF: begin
                    n_out_vld  = 1'b1;
                    n_out_kind = KIND_ECHO;
                    n_out_echo = BYTE_LF;
                    n_out_code = CODE_INVALID;
                    n_out_last = 1'b0;
                end
                PH_DECIDE: begin
                    n_out_vld  = 1'b1;
                    n_out_kind = KIND_DECISION;
                    n_out_echo = BYTE_NUL;
                    n_out_code = r_code;
                    n_out_last = 1'b1;
                end
                PH_IDLE: begin
                    if (r_in_vld) begin
                        n_out_kind = KIND_ECHO;
                        n_out_echo = r_in_byte;
                        n_out_code = CODE_INVALID;
                        n_out_last = 1'b1;
                        if (r_in_byte == BYTE_CR) begin
                            n_out_vld      = 1'b1;
                            n_out_last     = 1'b0;
                            line_cmd.clear = 1'b1;
                        end else if ((r_in_byte == BYTE_NUL) || (r_in_byte == BYTE_BS)) begin
                            n_out_vld = 1'b0;
                        end else if (r_in_byte == BYTE_DEL) begin
                            n_out_vld       = !line_stat.empty;
                            line_cmd.remove = !line_stat.empty;
                        end else begin
                            // full line drops the byte without echo
                            n_out_vld       = !line_stat.full;
                            line_cmd.append = !line_stat.full;
                        end
                    end
                end
                default: n_out_vld = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_out_kind <= n_out_kind;
        r_out_echo <= n_out_echo;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
    end

    assign o_res_valid    = r_out_vld;
    assign o_kind         = r_out_kind;
    assign o_echo_byte    = r_out_echo;
    assign o_command_code = r_out_code;
    assign o_last         = r_out_last;

    a_decision_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_kind == KIND_DECISION)) |-> r_out_last)
        else $error("decision result not marked last");

    a_pending_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> r_out_vld)
        else $error("pending line ending without a result on the output");

    a_cr_starts_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && (r_in_byte == BYTE_CR)) |=>
            (r_phase == PH_LF) && r_out_vld && (r_out_echo == BYTE_CR) && !r_out_last)
        else $error("carriage return did not start the echo sequence");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_kind == KIND_DECISION)) |-> (r_out_code <= CODE_W'(NUM_KEYS)))
        else $error("command code out of range");

endmodule

// ===== dv/serial_command_line_decoder_chk.sv =====
module serial_command_line_decoder_chk
    import scld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    input  logic              i_rx_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic              i_kind,
    input  logic [7:0]        i_echo_byte,
    input  logic [CODE_W-1:0] i_command_code,
    input  logic              i_last,
    output int                o_errors,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [CODE_W-1:0] {
        CMD_INVALID,
        CMD_FANON,
        CMD_FANOFF,
        CMD_FAN20,
        CMD_FAN80,
        CMD_PID30,
        CMD_PID60,
        CMD_PID5,
        CMD_PID50,
        CMD_PID80,
        CMD_PID75,
        CMD_PID84,
        CMD_PID90,
        CMD_PID94
    } t_cmd;

    typedef struct packed {
        logic              kind;
        logic [7:0]        echo_byte;
        logic [CODE_W-1:0] code;
        logic              last;
    } t_reply;

    t_reply     replies_due [$];
    logic [7:0] line_chars [LINE_DEPTH];
    int         line_count  = 0;
    int         error_count = 0;

    function automatic string command_word(t_cmd c);
        case (c)
            CMD_FANON:  return "FANON";
            CMD_FANOFF: return "FANOFF";
            CMD_FAN20:  return "FAN20";
            CMD_FAN80:  return "FAN80";
            CMD_PID30:  return "PID30";
            CMD_PID60:  return "PID60";
            CMD_PID5:   return "PID5";
            CMD_PID50:  return "PID50";
            CMD_PID80:  return "PID80";
            CMD_PID75:  return "PID75";
            CMD_PID84:  return "PID84";
            CMD_PID90:  return "PID90";
            CMD_PID94:  return "PID94";
            default:    return "";
        endcase
    endfunction

    // whole line must equal the word, earliest word in the list wins
    function automatic t_cmd look_up_line();
        t_cmd  hit;
        string word;
        logic  same;
        hit = CMD_INVALID;
        for (int k = CMD_FANON; k <= CMD_PID94; k++) begin
            word = command_word(t_cmd'(k));
            if (hit == CMD_INVALID && word.len() == line_count) begin
                same = 1'b1;
                for (int i = 0; i < line_count; i++) begin
                    if (line_chars[i] != word[i]) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    hit = t_cmd'(k);
                end
            end
        end
        return hit;
    endfunction

    function automatic t_reply echo_of(logic [7:0] b, logic fin);
        return '{kind: KIND_ECHO, echo_byte: b, code: CMD_INVALID, last: fin};
    endfunction

    task automatic edit_line(input logic [7:0] b);
        t_reply decision;
        if (b == BYTE_CR) begin
            decision = '{kind: KIND_DECISION, echo_byte: 8'h00, code: look_up_line(),
                         last: 1'b1};
            replies_due.push_back(echo_of(BYTE_CR, 1'b0));
            replies_due.push_back(echo_of(BYTE_LF, 1'b0));
            replies_due.push_back(decision);
            line_count = 0;
        end else if (b == BYTE_DEL) begin
            if (line_count > 0) begin
                line_count--;
                replies_due.push_back(echo_of(BYTE_DEL, 1'b1));
            end
        end else if (b != BYTE_NUL && b != BYTE_BS && line_count < LINE_DEPTH) begin
            // a full line swallows the byte without echo
            line_chars[line_count] = b;
            line_count++;
            replies_due.push_back(echo_of(b, 1'b1));
        end
    endtask

    task automatic check_reply();
        t_reply got;
        t_reply want;
        got = '{kind: i_kind, echo_byte: i_echo_byte, code: i_command_code, last: i_last};
        if (replies_due.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
                $display("unexpected result: kind %0d echo %02h code %0d last %0d",
                         got.kind, got.echo_byte, got.code, got.last);
            end
        end else begin
            want = replies_due.pop_front();
            if (got.kind !== want.kind || got.echo_byte !== want.echo_byte ||
                got.code !== want.code || got.last !== want.last) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("mismatch: expected kind %0d echo %02h code %0d last %0d",
                             want.kind, want.echo_byte, want.code, want.last);
                    $display("          got      kind %0d echo %02h code %0d last %0d",
                             got.kind, got.echo_byte, got.code, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            replies_due.delete();
            line_count = 0;
        end else begin
            if (i_rx_valid && i_rx_ready) begin
                edit_line(i_rx_byte);
            end
            if (i_res_valid && i_res_ready) begin
                check_reply();
            end
        end
        o_errors  <= error_count;
        o_pending <= replies_due.size();
    end

endmodule

// ===== dv/serial_command_line_decoder_tb.sv =====
module serial_command_line_decoder_tb;
    import scld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 160;

    logic              clk;
    logic              rst_n;
    logic              rx_valid;
    logic              rx_ready;
    logic [7:0]        rx_byte;
    logic              res_valid;
    logic              res_ready;
    logic              kind;
    logic [7:0]        echo_byte;
    logic [CODE_W-1:0] command_code;
    logic              last;
    int                errors;
    int                pending;
    int                items_sent;

    serial_command_line_decoder u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_kind         (kind),
        .o_echo_byte    (echo_byte),
        .o_command_code (command_code),
        .o_last         (last)
    );

    serial_command_line_decoder_chk u_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .i_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .i_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .i_kind         (kind),
        .i_echo_byte    (echo_byte),
        .i_command_code (command_code),
        .i_last         (last),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic string word_for(int idx);
        case (idx)
            0:       return "FANON";
            1:       return "FANOFF";
            2:       return "FAN20";
            3:       return "FAN80";
            4:       return "PID30";
            5:       return "PID60";
            6:       return "PID5";
            7:       return "PID50";
            8:       return "PID80";
            9:       return "PID75";
            10:      return "PID84";
            11:      return "PID90";
            default: return "PID94";
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic is_special(logic [7:0] b);
        return b == BYTE_NUL || b == BYTE_BS || b == BYTE_CR || b == BYTE_DEL;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (is_special(b));
        return b;
    endfunction

    // called and returning at a falling edge; valid stays up when no gap follows
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = ((items_sent % 40) < 8) ? 0 : gap_len();
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do begin
            @(posedge clk);
        end while (!(rx_valid && rx_ready));
        @(negedge clk);
        if (b != BYTE_NUL && b != BYTE_BS) begin
            items_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_command(input int seq_no);
        string      word;
        int         r;
        int         pos;
        int         n;
        logic [7:0] c;
        r = (seq_no == 0) ? 75 : $urandom_range(0, 99);
        word = word_for($urandom_range(0, 12));
        if (r < 55) begin
            // valid command typed with the odd slip, corrected, and stray nulls or backspaces
            for (int i = 0; i < word.len(); i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(plain_byte());
                    send_byte(BYTE_DEL);
                end
                if ($urandom_range(0, 19) == 0) begin
                    send_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_NUL);
                end
                send_byte(word[i]);
            end
            send_byte(BYTE_CR);
        end else if (r < 70) begin
            // near miss: shortened, one character corrupted, or one too many
            n = $urandom_range(0, 2);
            if (n == 0) begin
                word = word.substr(0, word.len() - 2);
            end else if (n == 1) begin
                pos = $urandom_range(0, word.len() - 1);
                c = word[pos] ^ (8'h01 << $urandom_range(0, 7));
                word[pos] = is_special(c) ? "X" : c;
            end else begin
                word = {word, "0"};
            end
            send_text(word);
            send_byte(BYTE_CR);
        end else if (r < 80) begin
            // fill the line to near or past its depth, then trim a little
            n = $urandom_range(18, 28);
            for (int i = 0; i < n; i++) begin
                send_byte(plain_byte());
            end
            repeat ($urandom_range(0, 3)) send_byte(BYTE_DEL);
            send_byte(plain_byte());
            send_byte(BYTE_CR);
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1)) begin
                send_byte(BYTE_CR);
            end
        end
    endtask

    // result side: random stalls, calm stretches, and one long hold-off
    initial begin : result_side
        int ticks;
        int hold;
        res_ready = 1'b0;
        ticks = 0;
        hold  = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            ticks++;
            if (ticks == 250) begin
                hold = 200;
            end
            if (hold > 0) begin
                res_ready <= 1'b0;
                hold--;
            end else begin
                res_ready <= 1'b1;
                hold = (((ticks / 128) % 4) == 3) ? 0 : gap_len();
            end
        end
    end

    initial begin : stimulus
        int seq_no;
        int drain;
        rst_n      = 1'b0;
        rx_valid   = 1'b0;
        rx_byte    = 8'h00;
        items_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ignored bytes, delete on an empty line, empty line
        send_byte(BYTE_NUL);
        send_byte(BYTE_BS);
        send_byte(BYTE_DEL);
        send_byte(BYTE_CR);
        // shortest and longest command words
        send_text("PID5");
        send_byte(BYTE_CR);
        send_text("FANOFF");
        send_byte(BYTE_CR);
        // high bytes are kept and echoed, then edited away
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(BYTE_DEL);
        send_byte(BYTE_DEL);
        send_byte(BYTE_CR);

        seq_no = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            send_command(seq_no);
            seq_no++;
        end
        rx_valid <= 1'b0;

        drain = 0;
        while (pending != 0 && drain < 20000) begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
